// File: hdl/imht_pkg.sv
// ----------------------------------------------------------------------------
// imht_pkg
// Shared types and constants of the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package imht_pkg;

  // Default sizes of the queue.
  localparam int HEAP_CAPACITY_DEF = 32;
  localparam int ID_COUNT_DEF      = 64;
  localparam int TIME_BITS_DEF     = 32;

  // Field widths of requests and results.
  localparam int ACTION_W  = 3;
  localparam int ID_W      = 6;
  localparam int TIMEOUT_W = 24;
  localparam int ELAPSED_W = 8;
  localparam int KIND_W    = 2;
  localparam int WAIT_W    = 25;
  localparam int STATUS_W  = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // A tick reports at most this many expired timers.
  localparam int MAX_FIRES = 32;
  localparam int FIRE_W    = 6;

  localparam logic [TIMEOUT_W-1:0] WAIT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET   = 3'd0,
    ACT_REARM = 3'd1,
    ACT_FIRE  = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED  = 2'd0,
    KIND_WAIT   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_INS_START,
    OP_REARM_START,
    OP_REMOVE,
    OP_REM_LOAD,
    OP_SD_READ,
    OP_SD_STEP,
    OP_SU_READ,
    OP_SU_STEP,
    OP_PLACE,
    OP_TICK_START,
    OP_TICK_READ,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    kind_t   res_kind;
    status_t res_status;
    logic    res_last;
    logic    from_top;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic known;
    logic id_ok;
    logic full;
    logic rem_tail;
    logic sd_end;
    logic sd_stop;
    logic su_end;
    logic su_stop;
    logic moved;
    logic expired;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/imht_dp.sv
// ----------------------------------------------------------------------------
// imht_dp
// Datapath: heap memories, id-to-slot map, clock, hole registers, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module imht_dp #(
  parameter int HEAP_CAPACITY = imht_pkg::HEAP_CAPACITY_DEF,
  parameter int ID_COUNT      = imht_pkg::ID_COUNT_DEF,
  parameter int TIME_BITS     = imht_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [imht_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [imht_pkg::ID_W-1:0]       in_id,
  input  wire logic [imht_pkg::TIMEOUT_W-1:0]  in_timeout,
  input  wire logic [imht_pkg::ELAPSED_W-1:0]  in_elapsed,
  input  wire imht_pkg::dp_cmd_t               cmd,
  output imht_pkg::dp_stat_t                   stat,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [imht_pkg::KIND_W-1:0]          out_kind,
  output logic [imht_pkg::ID_W-1:0]            out_id,
  output logic [imht_pkg::WAIT_W-1:0]          out_wait,
  output logic [imht_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_last
);

  localparam int SW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
  localparam int CW = $clog2(HEAP_CAPACITY + 1);
  localparam int KW = SW + 2;
  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int WW = (TIME_BITS > imht_pkg::WAIT_W) ? TIME_BITS : imht_pkg::WAIT_W;

  typedef logic [TIME_BITS-1:0] tm_t;
  typedef logic [imht_pkg::ID_W-1:0] id_t;

  function automatic logic earlier(input tm_t a, input tm_t b);
    tm_t d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  // Memories.
  tm_t          hp_dl  [HEAP_CAPACITY];
  id_t          hp_own [HEAP_CAPACITY];
  logic [SW-1:0] smap  [ID_COUNT];

  // Request and working registers.
  logic [imht_pkg::ACTION_W-1:0] act_r;
  id_t                 id_r;
  tm_t                 dl_r;
  logic [imht_pkg::ELAPSED_W-1:0] el_r;
  tm_t                 cur_time;
  logic [CW-1:0]       count;
  logic [CW-1:0]       lim;
  logic [SW-1:0]       pos;
  tm_t                 e_dl;
  id_t                 e_own;
  logic                moved;
  logic [imht_pkg::FIRE_W-1:0] fires;
  logic [ID_COUNT-1:0] present;
  tm_t                 ra_dl, rb_dl;
  id_t                 ra_own, rb_own;
  logic [SW-1:0]       slot_rd;

  // Memory port controls.
  logic          rd_a, rd_b, hp_we, sm_we;
  logic [SW-1:0] ra_addr, rb_addr, hp_waddr, sm_wdata;
  tm_t           hp_wdl;
  id_t           hp_wown;
  logic [IW-1:0] sm_waddr;

  logic [KW-1:0] k, kp1, lim_k;
  logic          c_sel;
  tm_t           c_dl;
  id_t           c_own;
  logic [SW-1:0] c_idx, parent;
  logic [CW-1:0] count_m1;
  logic [SW-1:0] rem_pos;
  id_t           rem_id;
  logic          out_free;
  tm_t           diff;
  logic [WW-1:0] diff_w;
  logic [imht_pkg::WAIT_W-1:0] wait_val;

  assign k        = KW'({pos, 1'b1});
  assign kp1      = k + KW'(1);
  assign lim_k    = KW'(lim);
  assign c_sel    = (kp1 < lim_k) && earlier(rb_dl, ra_dl);
  assign c_dl     = c_sel ? rb_dl : ra_dl;
  assign c_own    = c_sel ? rb_own : ra_own;
  assign c_idx    = c_sel ? kp1[SW-1:0] : k[SW-1:0];
  assign parent   = SW'((pos - SW'(1)) >> 1);
  assign count_m1 = count - CW'(1);
  assign rem_pos  = cmd.from_top ? '0 : slot_rd;
  assign rem_id   = cmd.from_top ? ra_own : id_r;
  assign out_free = !out_valid || out_ready;

  // Time to the earliest deadline, clamped; all ones when the queue is empty.
  assign diff   = ra_dl - cur_time;
  assign diff_w = WW'(diff);
  always_comb begin
    if (count == '0) begin
      wait_val = '1;
    end else if (!earlier(cur_time, ra_dl)) begin
      wait_val = '0;
    end else if (diff_w > WW'(imht_pkg::WAIT_MAX)) begin
      wait_val = {1'b0, imht_pkg::WAIT_MAX};
    end else begin
      wait_val = {1'b0, diff_w[imht_pkg::TIMEOUT_W-1:0]};
    end
  end

  always_comb begin
    stat.act      = act_r;
    stat.id_ok    = int'(id_r) < ID_COUNT;
    stat.known    = stat.id_ok && present[IW'(id_r)];
    stat.full     = count >= CW'(HEAP_CAPACITY);
    stat.rem_tail = KW'(pos) >= lim_k;
    stat.sd_end   = k >= lim_k;
    stat.sd_stop  = earlier(e_dl, c_dl);
    stat.su_end   = pos == '0;
    stat.su_stop  = earlier(ra_dl, e_dl);
    stat.moved    = moved;
    stat.expired  = (count != '0) && (int'(fires) < imht_pkg::MAX_FIRES) &&
                    !earlier(cur_time, ra_dl);
    stat.out_free = out_free;
  end

  // Memory port selection for each command.
  always_comb begin
    rd_a     = 1'b0;
    rd_b     = 1'b0;
    ra_addr  = '0;
    rb_addr  = '0;
    hp_we    = 1'b0;
    hp_waddr = pos;
    hp_wdl   = e_dl;
    hp_wown  = e_own;
    sm_we    = 1'b0;
    sm_waddr = IW'(e_own);
    sm_wdata = pos;
    unique case (cmd.op)
      imht_pkg::OP_REMOVE: begin
        rd_a    = 1'b1;
        ra_addr = SW'(count_m1);
      end
      imht_pkg::OP_SD_READ: begin
        rd_a    = 1'b1;
        rd_b    = 1'b1;
        ra_addr = k[SW-1:0];
        rb_addr = kp1[SW-1:0];
      end
      imht_pkg::OP_SD_STEP: begin
        hp_we    = 1'b1;
        hp_wdl   = c_dl;
        hp_wown  = c_own;
        sm_we    = 1'b1;
        sm_waddr = IW'(c_own);
      end
      imht_pkg::OP_SU_READ: begin
        rd_a    = 1'b1;
        ra_addr = parent;
      end
      imht_pkg::OP_SU_STEP: begin
        hp_we    = 1'b1;
        hp_wdl   = ra_dl;
        hp_wown  = ra_own;
        sm_we    = 1'b1;
        sm_waddr = IW'(ra_own);
      end
      imht_pkg::OP_PLACE: begin
        hp_we = 1'b1;
        sm_we = 1'b1;
      end
      imht_pkg::OP_TICK_START, imht_pkg::OP_TICK_READ: begin
        rd_a = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      hp_dl[hp_waddr]  <= hp_wdl;
      hp_own[hp_waddr] <= hp_wown;
    end
    if (rd_a) begin
      ra_dl  <= hp_dl[ra_addr];
      ra_own <= hp_own[ra_addr];
    end
    if (rd_b) begin
      rb_dl  <= hp_dl[rb_addr];
      rb_own <= hp_own[rb_addr];
    end
    if (sm_we) begin
      smap[sm_waddr] <= sm_wdata;
    end
    if (cmd.op == imht_pkg::OP_LOAD) begin
      slot_rd <= smap[IW'(in_id)];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      imht_pkg::OP_LOAD: begin
        act_r <= in_action;
        id_r  <= in_id;
        el_r  <= in_elapsed;
        dl_r  <= cur_time + TIME_BITS'(in_timeout);
      end
      imht_pkg::OP_INS_START: begin
        pos   <= SW'(count);
        e_dl  <= dl_r;
        e_own <= id_r;
      end
      imht_pkg::OP_REARM_START: begin
        pos   <= slot_rd;
        lim   <= count;
        e_dl  <= dl_r;
        e_own <= id_r;
      end
      imht_pkg::OP_REMOVE: begin
        pos <= rem_pos;
        lim <= count_m1;
      end
      imht_pkg::OP_REM_LOAD: begin
        e_dl  <= ra_dl;
        e_own <= ra_own;
      end
      imht_pkg::OP_SD_STEP: pos <= c_idx;
      imht_pkg::OP_SU_STEP: pos <= parent;
      default: begin
      end
    endcase
    if (cmd.op == imht_pkg::OP_EMIT) begin
      out_kind   <= cmd.res_kind;
      out_id     <= '0;
      out_wait   <= (cmd.res_kind == imht_pkg::KIND_WAIT) ? wait_val : '0;
      out_status <= cmd.res_status;
      out_last   <= cmd.res_last;
    end else if (cmd.op == imht_pkg::OP_REMOVE) begin
      out_kind   <= imht_pkg::KIND_FIRED;
      out_id     <= rem_id;
      out_wait   <= '0;
      out_status <= imht_pkg::ST_OK;
      out_last   <= cmd.res_last;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time  <= '0;
      count     <= '0;
      present   <= '0;
      moved     <= 1'b0;
      fires     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == imht_pkg::OP_EMIT || cmd.op == imht_pkg::OP_REMOVE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        imht_pkg::OP_CLEAR: begin
          count   <= '0;
          present <= '0;
        end
        imht_pkg::OP_INS_START: begin
          count              <= count + CW'(1);
          present[IW'(id_r)] <= 1'b1;
        end
        imht_pkg::OP_REARM_START, imht_pkg::OP_REM_LOAD: moved <= 1'b0;
        imht_pkg::OP_REMOVE: begin
          count                <= count_m1;
          present[IW'(rem_id)] <= 1'b0;
          fires                <= fires + imht_pkg::FIRE_W'(1);
        end
        imht_pkg::OP_SD_STEP: moved <= 1'b1;
        imht_pkg::OP_TICK_START: begin
          cur_time <= cur_time + TIME_BITS'(el_r);
          fires    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/imht_ctrl.sv
// ----------------------------------------------------------------------------
// imht_ctrl
// Controller: sequences requests, sifts and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module imht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire imht_pkg::dp_stat_t stat,
  output imht_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RM, S_TK_CHK, S_REM_LD, S_SD_RD, S_SD_CMP,
    S_SU_RD, S_SU_CMP, S_PLACE, S_FINISH, S_EMIT
  } state_t;

  state_t             state, state_next;
  imht_pkg::kind_t    res_kind, res_kind_next;
  imht_pkg::status_t  res_status, res_status_next;
  logic               is_tick;

  assign is_tick  = stat.act == imht_pkg::ACT_TICK;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next      = state;
    res_kind_next   = res_kind;
    res_status_next = res_status;
    cmd.op          = imht_pkg::OP_NONE;
    cmd.res_kind    = res_kind;
    cmd.res_status  = res_status;
    cmd.res_last    = 1'b1;
    cmd.from_top    = is_tick;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = imht_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_kind_next   = imht_pkg::KIND_STATUS;
        res_status_next = imht_pkg::ST_OK;
        unique case (stat.act)
          imht_pkg::ACT_SET: begin
            if (stat.known) begin
              cmd.op     = imht_pkg::OP_REARM_START;
              state_next = S_SD_RD;
            end else if (!stat.id_ok) begin
              res_status_next = imht_pkg::ST_UNKNOWN;
              state_next      = S_EMIT;
            end else if (stat.full) begin
              res_status_next = imht_pkg::ST_FULL;
              state_next      = S_EMIT;
            end else begin
              cmd.op     = imht_pkg::OP_INS_START;
              state_next = S_SU_RD;
            end
          end
          imht_pkg::ACT_REARM: begin
            if (stat.known) begin
              cmd.op     = imht_pkg::OP_REARM_START;
              state_next = S_SD_RD;
            end else begin
              res_status_next = imht_pkg::ST_UNKNOWN;
              state_next      = S_EMIT;
            end
          end
          imht_pkg::ACT_FIRE: begin
            if (stat.known) begin
              state_next = S_RM;
            end else begin
              res_status_next = imht_pkg::ST_UNKNOWN;
              state_next      = S_EMIT;
            end
          end
          imht_pkg::ACT_TICK: begin
            cmd.op     = imht_pkg::OP_TICK_START;
            state_next = S_TK_CHK;
          end
          imht_pkg::ACT_CLEAR: begin
            cmd.op     = imht_pkg::OP_CLEAR;
            state_next = S_EMIT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RM: begin
        cmd.res_last = !is_tick;
        if (stat.out_free) begin
          cmd.op     = imht_pkg::OP_REMOVE;
          state_next = S_REM_LD;
        end
      end
      S_TK_CHK: begin
        if (stat.expired) begin
          state_next = S_RM;
        end else begin
          res_kind_next   = imht_pkg::KIND_WAIT;
          res_status_next = imht_pkg::ST_OK;
          state_next      = S_EMIT;
        end
      end
      S_REM_LD: begin
        if (stat.rem_tail) begin
          state_next = S_FINISH;
        end else begin
          cmd.op     = imht_pkg::OP_REM_LOAD;
          state_next = S_SD_RD;
        end
      end
      S_SD_RD: begin
        if (stat.sd_end) begin
          state_next = stat.moved ? S_PLACE : S_SU_RD;
        end else begin
          cmd.op     = imht_pkg::OP_SD_READ;
          state_next = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (stat.sd_stop) begin
          state_next = stat.moved ? S_PLACE : S_SU_RD;
        end else begin
          cmd.op     = imht_pkg::OP_SD_STEP;
          state_next = S_SD_RD;
        end
      end
      S_SU_RD: begin
        if (stat.su_end) begin
          state_next = S_PLACE;
        end else begin
          cmd.op     = imht_pkg::OP_SU_READ;
          state_next = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (stat.su_stop) begin
          state_next = S_PLACE;
        end else begin
          cmd.op     = imht_pkg::OP_SU_STEP;
          state_next = S_SU_RD;
        end
      end
      S_PLACE: begin
        cmd.op     = imht_pkg::OP_PLACE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (is_tick) begin
          cmd.op     = imht_pkg::OP_TICK_READ;
          state_next = S_TK_CHK;
        end else if (stat.act == imht_pkg::ACT_FIRE) begin
          state_next = S_IDLE;
        end else begin
          res_kind_next   = imht_pkg::KIND_STATUS;
          res_status_next = imht_pkg::ST_OK;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = imht_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_kind   <= imht_pkg::KIND_STATUS;
      res_status <= imht_pkg::ST_OK;
    end else begin
      state      <= state_next;
      res_kind   <= res_kind_next;
      res_status <= res_status_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/indexed_min_heap_timer.sv
// Timing: a set or re-arm registers its status result after its sift, which takes a
// read step and a compare step per heap level.
// A tick advances the clock, then removes and reports each expired timer in turn,
// and a result the receiver has not taken yet holds the controller until it leaves.
// Throughput: one request at a time; the next is accepted once the controller is
// idle, while the last result may still wait. Reset: synchronous rst empties the queue.
// ----------------------------------------------------------------------------
// indexed_min_heap_timer
// Timer queue keyed by id, kept as a binary min-heap with an id-to-slot map.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_timer #(
  parameter int HEAP_CAPACITY = imht_pkg::HEAP_CAPACITY_DEF,
  parameter int ID_COUNT      = imht_pkg::ID_COUNT_DEF,
  parameter int TIME_BITS     = imht_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // timer_id [5:0], timeout_ms [29:6], elapsed_ms [37:30], zero pad [39:38].
  input  wire logic [imht_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action [2:0].
  input  wire logic [imht_pkg::ACTION_W-1:0]     s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // fired_id [5:0], wait_ms [30:6], status [32:31], zero pad [39:33].
  output logic [imht_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // kind [1:0].
  output logic [imht_pkg::KIND_W-1:0]            m_axis_tuser,
  output logic                                   m_axis_tlast
);

  imht_pkg::dp_cmd_t  cmd;
  imht_pkg::dp_stat_t stat;

  logic [imht_pkg::ID_W-1:0]     out_id;
  logic [imht_pkg::WAIT_W-1:0]   out_wait;
  logic [imht_pkg::STATUS_W-1:0] out_status;

  // The controller walks each request through decode, sift and emit steps.
  imht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the heap, the slot map, the clock and the result register.
  imht_dp #(
    .HEAP_CAPACITY (HEAP_CAPACITY),
    .ID_COUNT      (ID_COUNT),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_action  (s_axis_tuser),
    .in_id      (s_axis_tdata[5:0]),
    .in_timeout (s_axis_tdata[29:6]),
    .in_elapsed (s_axis_tdata[37:30]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_id     (out_id),
    .out_wait   (out_wait),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

  // Result fields are packed from the lowest bit up.
  assign m_axis_tdata = {7'd0, out_status, out_wait, out_id};

`ifndef SYNTHESIS
  // Only a wait report carries a wait value.
  a_wait_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != imht_pkg::KIND_WAIT) |-> m_axis_tdata[30:6] == '0)
    else $error("wait field set outside a wait report");

  // Only a fired report carries an id.
  a_id_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != imht_pkg::KIND_FIRED) |-> m_axis_tdata[5:0] == '0)
    else $error("id field set outside a fired report");

  // A status result is always the final result of its request.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == imht_pkg::KIND_STATUS) |-> m_axis_tlast)
    else $error("status result not marked last");
`endif

endmodule

`default_nettype wire

// File: tb/indexed_min_heap_timer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_check
// Watches both streams of the timer queue, keeps its own heap and clock, and
// compares every report with the one predicted for it.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_timer_check
  import imht_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [ACTION_W-1:0]    s_axis_tuser,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic [KIND_W-1:0]      m_axis_tuser,
  input  wire logic                   m_axis_tlast,
  output int                          errors,
  output int                          pending
);

  localparam int CAP = HEAP_CAPACITY_DEF;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [WAIT_W-1:0] wt;
    status_t           st;
    logic              last;
  } timer_report_t;

  timer_report_t report_q[$];

  logic [31:0]     deadline [CAP];
  logic [ID_W-1:0] owner    [CAP];
  int              slot_of  [64];
  bit              armed    [64];
  int              count;
  logic [31:0]     now_ms;
  int              mism;

  // Wrap-safe ordering: a strictly before b.
  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  task automatic swap_slots(int i, int j);
    logic [31:0] dl;
    logic [ID_W-1:0] ow;
    dl = deadline[i]; ow = owner[i];
    deadline[i] = deadline[j]; owner[i] = owner[j];
    deadline[j] = dl; owner[j] = ow;
    slot_of[owner[i]] = i;
    slot_of[owner[j]] = j;
  endtask

  task automatic sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (earlier(deadline[p], deadline[i])) break;
      swap_slots(p, i);
      i = p;
    end
  endtask

  task automatic sift_down(int i, int n, output bit moved);
    int j, k;
    j = i;
    k = 2 * j + 1;
    while (k < n) begin
      if (k + 1 < n && earlier(deadline[k+1], deadline[k])) k++;
      if (earlier(deadline[j], deadline[k])) break;
      swap_slots(j, k);
      j = k;
      k = 2 * j + 1;
    end
    moved = (j > i);
  endtask

  task automatic remove_at(int i);
    int n;
    bit moved;
    n = count - 1;
    if (i < n) begin
      swap_slots(i, n);
      sift_down(i, n, moved);
      if (!moved) sift_up(i);
    end
    armed[owner[n]] = 0;
    count = n;
  endtask

  task automatic rearm_slot(int i, logic [31:0] dl);
    bit moved;
    deadline[i] = dl;
    sift_down(i, count, moved);
    if (!moved) sift_up(i);
  endtask

  task automatic push(kind_t k, logic [ID_W-1:0] id, logic [WAIT_W-1:0] wt, status_t st);
    timer_report_t r;
    r = '{kind: k, id: id, wt: wt, st: st, last: 1'b0};
    report_q.insert(report_q.size(), r);
  endtask

  // Applies one accepted request and queues the reports it should cause.
  task automatic apply_request(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                               logic [TIMEOUT_W-1:0] tmo, logic [ELAPSED_W-1:0] el);
    int          before_n, fires, i;
    logic [31:0] dl, d;
    before_n = report_q.size();
    dl = now_ms + 32'(tmo);
    case (act)
      ACT_SET: begin
        if (armed[id]) begin
          rearm_slot(slot_of[id], dl);
          push(KIND_STATUS, '0, '0, ST_OK);
        end else if (count >= CAP) begin
          push(KIND_STATUS, '0, '0, ST_FULL);
        end else begin
          i = count;
          count++;
          deadline[i] = dl;
          owner[i] = id;
          slot_of[id] = i;
          armed[id] = 1;
          sift_up(i);
          push(KIND_STATUS, '0, '0, ST_OK);
        end
      end
      ACT_REARM: begin
        if (armed[id]) begin
          rearm_slot(slot_of[id], dl);
          push(KIND_STATUS, '0, '0, ST_OK);
        end else begin
          push(KIND_STATUS, '0, '0, ST_UNKNOWN);
        end
      end
      ACT_FIRE: begin
        if (armed[id]) begin
          remove_at(slot_of[id]);
          push(KIND_FIRED, id, '0, ST_OK);
        end else begin
          push(KIND_STATUS, '0, '0, ST_UNKNOWN);
        end
      end
      ACT_TICK: begin
        fires = 0;
        now_ms = now_ms + 32'(el);
        while (count > 0 && fires < MAX_FIRES && !earlier(now_ms, deadline[0])) begin
          push(KIND_FIRED, owner[0], '0, ST_OK);
          fires++;
          remove_at(0);
        end
        if (count == 0) begin
          push(KIND_WAIT, '0, '1, ST_OK);
        end else if (!earlier(now_ms, deadline[0])) begin
          push(KIND_WAIT, '0, '0, ST_OK);
        end else begin
          d = deadline[0] - now_ms;
          if (d > 32'(WAIT_MAX)) d = 32'(WAIT_MAX);
          push(KIND_WAIT, '0, d[WAIT_W-1:0], ST_OK);
        end
      end
      ACT_CLEAR: begin
        count = 0;
        foreach (armed[k]) armed[k] = 0;
        push(KIND_STATUS, '0, '0, ST_OK);
      end
      default: ;
    endcase
    if (report_q.size() > before_n) report_q[report_q.size()-1].last = 1'b1;
  endtask

  timer_report_t got, want;

  always @(posedge clk) begin
    mism = 0;
    if (rst) begin
      count  = 0;
      now_ms = '0;
      errors <= 0;
      foreach (armed[k]) armed[k] = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_request(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[29:6],
                      s_axis_tdata[37:30]);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: kind_t'(m_axis_tuser), id: m_axis_tdata[5:0],
                wt: m_axis_tdata[30:6], st: status_t'(m_axis_tdata[32:31]),
                last: m_axis_tlast};
        if (report_q.size() == 0) begin
          $error("unexpected report kind=%0d", got.kind);
          mism++;
        end else begin
          want = report_q.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mism++;
          end
          if (got.id !== want.id) begin
            $error("fired_id: expected %0d, got %0d", want.id, got.id);
            mism++;
          end
          if (got.wt !== want.wt) begin
            $error("wait_ms: expected %0d, got %0d", $signed(want.wt), $signed(got.wt));
            mism++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            mism++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mism++;
          end
        end
      end
      errors <= errors + mism;
    end
    pending = report_q.size();
  end

endmodule

`default_nettype wire

// File: tb/indexed_min_heap_timer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_test
// Drives the timer queue with directed and random requests under random
// stalls on both streams; the checker predicts and compares every report.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_timer_test;
  import imht_pkg::*;

  // Action codes past clear are ignored by the block.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = ACTION_W'(ACT_CLEAR + 1);
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = '1;
  localparam int RANDOM_REQUESTS = 354;
  localparam int FILL_COUNT      = 36;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;
  int                     errors;
  int                     pending;
  bit                     calm_sender;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_min_heap_timer u_top (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  indexed_min_heap_timer_check u_check (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors, .pending
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls, with stretches where it never stalls.
  int stall_left = 0;
  int calm_left  = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      calm_left <= $urandom_range(50, 300);
      m_axis_tready <= 1'b1;
    end else begin
      stall_left <= gap_len();
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one request and returns once it has been accepted.
  task automatic send(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                      logic [TIMEOUT_W-1:0] tmo, logic [ELAPSED_W-1:0] el);
    int g;
    g = calm_sender ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, el, tmo, id};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Random request: mostly set, re-arm, fire and tick with short timeouts so
  // timers actually expire; clears and ignored codes now and then.
  task automatic send_random();
    int r;
    logic [ID_W-1:0] id;
    logic [TIMEOUT_W-1:0] tmo;
    logic [ELAPSED_W-1:0] el;
    r   = $urandom_range(0, 99);
    id  = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 40));
    tmo = ($urandom_range(0, 9) == 0) ? TIMEOUT_W'($urandom) :
          TIMEOUT_W'($urandom_range(0, 400));
    el  = ($urandom_range(0, 4) == 0) ? ELAPSED_W'($urandom) :
          ELAPSED_W'($urandom_range(0, 40));
    if (r < 42)      send(ACT_SET, id, tmo, el);
    else if (r < 55) send(ACT_REARM, id, tmo, el);
    else if (r < 68) send(ACT_FIRE, id, tmo, el);
    else if (r < 95) send(ACT_TICK, id, tmo, el);
    else if (r < 97) send(ACT_CLEAR, id, tmo, el);
    else             send(ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), id, tmo, el);
  endtask

  initial begin
    calm_sender = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, extremes of every field, each action and the
    // unknown-id cases, equal deadlines, ignored codes and a clear.
    send(ACT_TICK,  0,  0, 0);
    send(ACT_REARM, 5, 10, 0);
    send(ACT_FIRE,  5,  0, 0);
    send(ACT_SET,   0,  0, 0);
    send(ACT_SET,  63, '1, '1);
    send(ACT_SET,  10, 20, 0);
    send(ACT_SET,  11, 20, 0);
    send(ACT_SET,  12, 20, 0);
    send(ACT_REARM, 63, 5, 0);
    send(ACT_SET,  10, 3, 0);
    send(ACT_FIRE, 11, 0, 0);
    send(ACT_TICK,  0, 0, 0);
    send(ACT_TICK, 42, 0, 8'd4);
    send(ACT_TICK,  0, 0, 8'd255);
    send(ACT_SPARE_LO, 7, 7, 7);
    send(ACT_SPARE_HI, 63, '1, '1);
    send(ACT_SET,  21, 24'h555555, 8'haa);
    send(ACT_SET,  42, 24'haaaaaa, 8'h55);
    send(ACT_CLEAR, 0, 0, 0);
    send(ACT_TICK,  0, 0, 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 59) == 0) calm_sender = !calm_sender;
      // Halfway through, fill the queue with distinct ids so the full status
      // is reached.
      if (n == RANDOM_REQUESTS / 2)
        for (int k = 0; k < FILL_COUNT; k++)
          send(ACT_SET, ID_W'(k), TIMEOUT_W'($urandom_range(0, 600)), 0);
      send_random();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("indexed_min_heap_timer_test: clean");
    else
      $display("indexed_min_heap_timer_test: errors");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("indexed_min_heap_timer_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
